// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising edge of aclk.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every rising edge of aclk.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/ps2mt_pkg.sv
// Types, constants and helper functions of the PS/2 mouse packet cursor tracker.
`default_nettype none

package ps2mt_pkg;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int DELTA_W = 9;

    // Cursor footprint subtracted from the screen size for the upper clamp.
    localparam logic [COORD_W-1:0] CURSOR_SIZE = 16'd8;

    // Reset values of the registers and the cursor.
    localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd800;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd600;
    localparam logic [COORD_W-1:0] CURSOR_RESET = 16'd200;

    // Header byte bit positions.
    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int HDR_XOVF_BIT = 6;
    localparam int HDR_YOVF_BIT = 7;

    // Configuration register indexes.
    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

    // Button transition event codes.
    localparam logic [2:0] EV_OTHER         = 3'd0;
    localparam logic [2:0] EV_MOVE_HELD     = 3'd1;
    localparam logic [2:0] EV_LEFT_PRESS    = 3'd2;
    localparam logic [2:0] EV_LEFT_RELEASE  = 3'd3;
    localparam logic [2:0] EV_RIGHT_PRESS   = 3'd4;
    localparam logic [2:0] EV_RIGHT_RELEASE = 3'd5;

    // Position of the next byte within a packet.
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } pos_t;

    // Add a movement to a coordinate and clamp it to 0 .. res - CURSOR_SIZE (0 when res is below CURSOR_SIZE).
    function automatic logic [COORD_W-1:0] clamp_axis(
        input logic [COORD_W-1:0] pos,
        input logic signed [DELTA_W:0] delta,
        input logic [COORD_W-1:0] res
    );
        logic signed [COORD_W+1:0] sum;
        logic [COORD_W-1:0] limit;
        logic [COORD_W-1:0] result;
        sum = $signed({2'b00, pos}) + $signed({{(COORD_W-DELTA_W+1){delta[DELTA_W]}}, delta});
        limit = (res >= CURSOR_SIZE) ? (res - CURSOR_SIZE) : '0;
        if (sum[COORD_W+1]) begin
            result = '0;
        end else if (sum[COORD_W:0] > {1'b0, limit}) begin
            result = limit;
        end else begin
            result = sum[COORD_W-1:0];
        end
        return result;
    endfunction

    // Classify the button change between two packets (bit 0 left, 1 right, 2 middle).
    function automatic logic [2:0] classify_event(
        input logic [2:0] prev,
        input logic [2:0] cur
    );
        logic [2:0] kind;
        kind = EV_OTHER;
        if (!prev[2] && !cur[2]) begin
            if (!prev[1] && !cur[1]) begin
                if (prev[0] && cur[0]) begin
                    kind = EV_MOVE_HELD;
                end else if (prev[0]) begin
                    kind = EV_LEFT_RELEASE;
                end else if (cur[0]) begin
                    kind = EV_LEFT_PRESS;
                end
            end
            if (!prev[0] && !cur[0]) begin
                if (prev[1] && cur[1]) begin
                    kind = EV_MOVE_HELD;
                end else if (prev[1]) begin
                    kind = EV_RIGHT_RELEASE;
                end else if (cur[1]) begin
                    kind = EV_RIGHT_PRESS;
                end
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ps2_mouse_packet_cursor_tracker_core.sv
// A word is registered in the input stage, and a third byte's packet result in the result stage.
// Throughput: one word per cycle; the input and result registers form a two-stage pipeline.
// A stalled result holds the pipeline only while both stages are full.
// Reset (aresetn low, synchronous) empties both stages, clears packet sync and buttons,
// puts the cursor at 200,200 and the screen size at 800 by 600.
`default_nettype none
`include "assert_macros.svh"

module ps2_mouse_packet_cursor_tracker_core
    import ps2mt_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [COORD_W-1:0]        cfg_wdata,
    // Input words
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_data_byte,
    input  wire logic                      s_from_aux,
    input  wire logic                      s_parity_err,
    input  wire logic                      s_timeout_err,
    // Packet results
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_left_button,
    output logic                           m_right_button,
    output logic                           m_middle_button,
    output logic                           m_x_overflow,
    output logic                           m_y_overflow,
    output logic signed [DELTA_W-1:0]      m_delta_x,
    output logic signed [DELTA_W-1:0]      m_delta_y,
    output logic [COORD_W-1:0]             m_cursor_x,
    output logic [COORD_W-1:0]             m_cursor_y,
    output logic [2:0]                     m_event_kind
);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_aux_reg;
    logic       in_par_reg;
    logic       in_tmo_reg;

    // Configuration registers
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;

    // Packet state
    pos_t               pos_reg, pos_next;
    logic [7:0]         header_reg, header_next;
    logic [7:0]         xbyte_reg, xbyte_next;
    logic [2:0]         buttons_reg, buttons_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;

    // Result stage
    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               out_buttons_reg;
    logic [1:0]               out_ovf_reg;
    logic [DELTA_W-1:0]       out_dx_reg;
    logic [DELTA_W-1:0]       out_dy_reg;
    logic [COORD_W-1:0]       out_col_reg;
    logic [COORD_W-1:0]       out_row_reg;
    logic [2:0]               out_kind_reg;

    // Datapath signals
    logic                     advance;
    logic                     byte_ok;
    logic                     emit;
    logic [DELTA_W-1:0]       dx;
    logic [DELTA_W-1:0]       dy;
    logic signed [DELTA_W:0]  dx_ext;
    logic signed [DELTA_W:0]  dy_neg;
    logic                     no_ovf;
    logic [2:0]               kind;

    // The input stage moves on whenever the result stage can take its word.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign byte_ok = in_aux_reg && !in_par_reg && !in_tmo_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_aux_reg  <= s_from_aux;
            in_par_reg  <= s_parity_err;
            in_tmo_reg  <= s_timeout_err;
        end
    end

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Packet decode of the third byte: deltas, overflow check and event.
    always_comb begin
        dx     = {header_reg[HDR_XSIGN_BIT], xbyte_reg};
        dy     = {header_reg[HDR_YSIGN_BIT], in_data_reg};
        dx_ext = $signed({dx[DELTA_W-1], dx});
        dy_neg = $signed({(DELTA_W+1){1'b0}}) - $signed({dy[DELTA_W-1], dy});
        no_ovf = !header_reg[HDR_XOVF_BIT] && !header_reg[HDR_YOVF_BIT];
        kind   = classify_event(buttons_reg, header_reg[2:0]);
    end

    // Byte position sequencer and state update.
    always_comb begin
        pos_next     = pos_reg;
        header_next  = header_reg;
        xbyte_next   = xbyte_reg;
        buttons_next = buttons_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        emit         = 1'b0;
        if (advance && byte_ok) begin
            case (pos_reg)
                POS_X: begin
                    xbyte_next = in_data_reg;
                    pos_next   = POS_Y;
                end
                POS_Y: begin
                    pos_next     = POS_HEADER;
                    emit         = 1'b1;
                    buttons_next = header_reg[2:0];
                    if (no_ovf) begin
                        col_next = clamp_axis(col_reg, dx_ext, width_reg);
                        row_next = clamp_axis(row_reg, dy_neg, height_reg);
                    end
                end
                default: begin
                    // Waiting for a header; bytes without the sync bit are skipped.
                    if (in_data_reg[HDR_SYNC_BIT]) begin
                        header_next = in_data_reg;
                        pos_next    = POS_X;
                    end else begin
                        pos_next = POS_HEADER;
                    end
                end
            endcase
        end
    end

    // Packet state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HEADER;
            header_reg  <= '0;
            xbyte_reg   <= '0;
            buttons_reg <= '0;
            col_reg     <= CURSOR_RESET;
            row_reg     <= CURSOR_RESET;
        end else begin
            pos_reg     <= pos_next;
            header_reg  <= header_next;
            xbyte_reg   <= xbyte_next;
            buttons_reg <= buttons_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // Result valid: set by a finished packet, cleared when the word is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (emit) begin
            out_buttons_reg <= header_reg[2:0];
            out_ovf_reg     <= {header_reg[HDR_YOVF_BIT], header_reg[HDR_XOVF_BIT]};
            out_dx_reg      <= dx;
            out_dy_reg      <= dy;
            out_col_reg     <= col_next;
            out_row_reg     <= row_next;
            out_kind_reg    <= kind;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_left_button   = out_buttons_reg[0];
    assign m_right_button  = out_buttons_reg[1];
    assign m_middle_button = out_buttons_reg[2];
    assign m_x_overflow    = out_ovf_reg[0];
    assign m_y_overflow    = out_ovf_reg[1];
    assign m_delta_x       = $signed(out_dx_reg);
    assign m_delta_y       = $signed(out_dy_reg);
    assign m_cursor_x      = out_col_reg;
    assign m_cursor_y      = out_row_reg;
    assign m_event_kind    = out_kind_reg;

    // A completed packet always shows up in the result stage.
    `ASSERT_NEXT(a_third_byte_emits, advance && byte_ok && pos_reg == POS_Y, m_valid)
    // A dropped byte leaves the packet position alone.
    `ASSERT_NEXT(a_drop_keeps_pos, advance && !byte_ok, $stable(pos_reg))
    // An overflowed packet does not move the cursor.
    `ASSERT_NEXT(a_overflow_holds_cursor, emit && !no_ovf, $stable(col_reg) && $stable(row_reg))

endmodule

`default_nettype wire

// File: bench/tb_ps2_mouse_packet_cursor_tracker_core.sv
// Self-checking testbench for the PS/2 mouse packet decoder and cursor tracker core.
module tb_ps2_mouse_packet_cursor_tracker_core
    import ps2mt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded mouse packet as it should leave the block.
    typedef struct {
        logic                      left_btn;
        logic                      right_btn;
        logic                      middle_btn;
        logic                      x_ovf;
        logic                      y_ovf;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [COORD_W-1:0]        cx;
        logic [COORD_W-1:0]        cy;
        logic [2:0]                kind;
    } packet_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [0:0]                cfg_index;
    logic [COORD_W-1:0]        cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [7:0]                s_data_byte;
    logic                      s_from_aux;
    logic                      s_parity_err;
    logic                      s_timeout_err;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_left_button;
    logic                      m_right_button;
    logic                      m_middle_button;
    logic                      m_x_overflow;
    logic                      m_y_overflow;
    logic signed [DELTA_W-1:0] m_delta_x;
    logic signed [DELTA_W-1:0] m_delta_y;
    logic [COORD_W-1:0]        m_cursor_x;
    logic [COORD_W-1:0]        m_cursor_y;
    logic [2:0]                m_event_kind;

    // Packets predicted but not yet seen on the result channel.
    packet_t pending_packets[$];
    int      error_count = 0;

    // Idle controls of the sender (send_gap_max) and the receiver (stall_max, hold_cycles).
    int send_gap_max;
    int stall_max;
    int hold_cycles;

    // Predictor state: packet framing, buttons, cursor and screen size.
    pos_t               mdl_pos;
    logic [7:0]         mdl_header;
    logic [7:0]         mdl_xbyte;
    logic [2:0]         mdl_buttons;
    logic [COORD_W-1:0] mdl_col;
    logic [COORD_W-1:0] mdl_row;
    logic [COORD_W-1:0] mdl_width;
    logic [COORD_W-1:0] mdl_height;

    ps2_mouse_packet_cursor_tracker_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_from_aux      (s_from_aux),
        .s_parity_err    (s_parity_err),
        .s_timeout_err   (s_timeout_err),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_button   (m_left_button),
        .m_right_button  (m_right_button),
        .m_middle_button (m_middle_button),
        .m_x_overflow    (m_x_overflow),
        .m_y_overflow    (m_y_overflow),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_event_kind    (m_event_kind)
    );

    always #2 aclk = ~aclk;

    // Move one coordinate and keep the cursor footprint on the screen.
    function automatic logic [COORD_W-1:0] clamp_coord(input int pos, input int delta,
                                                      input int res);
        int v;
        int lim;
        v = pos + delta;
        lim = res - int'(CURSOR_SIZE);
        if (lim < 0) lim = 0;
        if (v < 0) v = 0;
        if (v > lim) v = lim;
        return v[COORD_W-1:0];
    endfunction

    // Button transition between the previous and the current packet.
    function automatic logic [2:0] button_event(input logic [2:0] prev, input logic [2:0] cur);
        logic [2:0] kind;
        kind = EV_OTHER;
        if (!prev[2] && !cur[2]) begin
            if (!prev[1] && !cur[1]) begin
                if (prev[0] && cur[0]) begin
                    kind = EV_MOVE_HELD;
                end else begin
                    if (cur[0]) kind = EV_LEFT_PRESS;
                    if (prev[0]) kind = EV_LEFT_RELEASE;
                end
            end
            if (!prev[0] && !cur[0]) begin
                if (prev[1] && cur[1]) begin
                    kind = EV_MOVE_HELD;
                end else begin
                    if (cur[1]) kind = EV_RIGHT_PRESS;
                    if (prev[1]) kind = EV_RIGHT_RELEASE;
                end
            end
        end
        return kind;
    endfunction

    // Feed one accepted word to the predictor; a third byte yields a packet.
    function automatic void decode_word(input logic [7:0] b, input logic aux,
                                        input logic par, input logic tmo);
        packet_t p;
        int      dx;
        int      dy;
        if (!aux || par || tmo) return;
        case (mdl_pos)
            POS_X: begin
                mdl_xbyte = b;
                mdl_pos = POS_Y;
            end
            POS_Y: begin
                mdl_pos = POS_HEADER;
                dx = mdl_header[HDR_XSIGN_BIT] ? int'(mdl_xbyte) - 256 : int'(mdl_xbyte);
                dy = mdl_header[HDR_YSIGN_BIT] ? int'(b) - 256 : int'(b);
                // Rows grow downward, so a positive y movement lowers the row.
                if (mdl_header[HDR_YOVF_BIT:HDR_XOVF_BIT] == 2'b00) begin
                    mdl_col = clamp_coord(int'(mdl_col), dx, int'(mdl_width));
                    mdl_row = clamp_coord(int'(mdl_row), -dy, int'(mdl_height));
                end
                p.kind = button_event(mdl_buttons, mdl_header[2:0]);
                mdl_buttons = mdl_header[2:0];
                p.left_btn = mdl_header[0];
                p.right_btn = mdl_header[1];
                p.middle_btn = mdl_header[2];
                p.x_ovf = mdl_header[HDR_XOVF_BIT];
                p.y_ovf = mdl_header[HDR_YOVF_BIT];
                p.dx = {mdl_header[HDR_XSIGN_BIT], mdl_xbyte};
                p.dy = {mdl_header[HDR_YSIGN_BIT], b};
                p.cx = mdl_col;
                p.cy = mdl_row;
                pending_packets.push_back(p);
            end
            default: begin
                // Out of sync: only a byte with the sync bit starts a packet.
                if (b[HDR_SYNC_BIT]) begin
                    mdl_header = b;
                    mdl_pos = POS_X;
                end else begin
                    mdl_pos = POS_HEADER;
                end
            end
        endcase
    endfunction

    // Report one field that differs from the prediction.
    function automatic void check_field(input string name, input logic signed [16:0] expv,
                                        input logic signed [16:0] actv);
        if (actv !== expv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            error_count++;
        end
    endfunction

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input logic [7:0] data, input logic aux, input logic par,
                             input logic tmo);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_from_aux <= aux;
        s_parity_err <= par;
        s_timeout_err <= tmo;
        do @(posedge aclk); while (s_ready !== 1'b1);
        decode_word(data, aux, par, tmo);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
        send_word(hdr, 1'b1, 1'b0, 1'b0);
        send_word(xb, 1'b1, 1'b0, 1'b0);
        send_word(yb, 1'b1, 1'b0, 1'b0);
    endtask

    // A word with at least one flag that makes the block drop it.
    task automatic send_dropped_word();
        logic [2:0] flags;
        do flags = 3'($urandom_range(0, 7)); while (flags == 3'b001);
        send_word(8'($urandom), flags[0], flags[1], flags[2]);
    endtask

    // Well-formed packet with random content, now and then a dropped word in between.
    task automatic send_random_packet();
        logic [7:0] bytes [3];
        bytes[0] = 8'($urandom);
        bytes[0][HDR_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 7) != 0) bytes[0][HDR_YOVF_BIT:HDR_XOVF_BIT] = 2'b00;
        if ($urandom_range(0, 3) != 0) bytes[0][2] = 1'b0;
        bytes[1] = 8'($urandom);
        bytes[2] = 8'($urandom);
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 19) == 0) send_dropped_word();
            send_word(bytes[i], 1'b1, 1'b0, 1'b0);
        end
    endtask

    // Stop offering words, wait for every packet, then let the pipeline empty.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_packets.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [0:0] idx, input logic [COORD_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH) mdl_width = value;
        else mdl_height = value;
    endtask

    function automatic logic [COORD_W-1:0] pick_resolution();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(8, 64));
            1: return 16'($urandom_range(64, 1024));
            2: return 16'($urandom_range(0, 65535));
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 7));
            default: return 16'd8;
        endcase
    endfunction

    // Sync loss, dropped words, every event kind, overflow and delta extremes.
    task automatic test_directed_packets();
        send_word(8'h00, 1'b1, 1'b0, 1'b0);
        send_word(8'hF7, 1'b1, 1'b0, 1'b0);
        send_packet(8'h08, 8'h7F, 8'h80);
        send_word(8'h19, 1'b0, 1'b0, 1'b0);
        send_word(8'h19, 1'b1, 1'b1, 1'b0);
        send_packet(8'h19, 8'h00, 8'hFF);
        // A word with a timeout error inside a packet must not break the framing.
        send_word(8'h29, 1'b1, 1'b0, 1'b0);
        send_word(8'h55, 1'b1, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0, 1'b0);
        send_packet(8'h48, 8'h20, 8'h20);
        send_packet(8'h8A, 8'h20, 8'h20);
        send_packet(8'h3A, 8'h01, 8'h01);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'hFC, 8'hFF, 8'hFF);
        settle();
    endtask

    // Resolution extremes, screens smaller than the cursor, and overflow beyond a limit.
    task automatic test_screen_limits();
        write_reg(CFG_SCREEN_WIDTH, 16'hFFFF);
        write_reg(CFG_SCREEN_HEIGHT, 16'hFFFF);
        repeat (4) send_packet(8'h28, 8'hFF, 8'h01);
        settle();
        // The cursor now lies past the new limits; overflow packets must leave it there.
        write_reg(CFG_SCREEN_WIDTH, 16'd8);
        write_reg(CFG_SCREEN_HEIGHT, 16'd8);
        send_packet(8'hC8, 8'h10, 8'h10);
        send_packet(8'h48, 8'h10, 8'h10);
        send_packet(8'h08, 8'h00, 8'h00);
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd0);
        write_reg(CFG_SCREEN_HEIGHT, 16'd7);
        send_packet(8'h08, 8'h05, 8'h00);
        send_packet(8'h38, 8'h80, 8'h80);
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd9);
        write_reg(CFG_SCREEN_HEIGHT, 16'hFFFF);
        send_packet(8'h08, 8'h7F, 8'h00);
        send_packet(8'h28, 8'h00, 8'h01);
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd800);
        write_reg(CFG_SCREEN_HEIGHT, 16'd600);
    endtask

    // The receiver holds off for a long stretch while words keep coming back to back.
    task automatic test_backpressure();
        send_gap_max = 0;
        hold_cycles = 300;
        repeat (20) send_random_packet();
        settle();
        send_gap_max = 17;
    endtask

    // Random phases, each with its own screen size and idle pattern.
    task automatic test_random_traffic();
        int r;
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(CFG_SCREEN_WIDTH, pick_resolution());
            write_reg(CFG_SCREEN_HEIGHT, pick_resolution());
            send_gap_max = (phase == 2) ? 0 : 17;
            stall_max = (phase == 2) ? 0 : ((phase == 4) ? 3 : 17);
            for (int n = 0; n < 34; n++) begin
                r = $urandom_range(0, 99);
                if (r < 80) send_random_packet();
                else if (r < 90) send_dropped_word();
                else send_word(8'($urandom), 1'b1, 1'b0, 1'b0);
            end
            settle();
        end
        stall_max = 17;
    endtask

    // Result receiver: random stalls, or one long hold when requested.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, stall_max);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge aclk) begin : packet_check
        packet_t exp_pkt;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_packets.size() == 0) begin
                $error("result word with no packet expected");
                error_count++;
            end else begin
                exp_pkt = pending_packets.pop_front();
                check_field("left_button", exp_pkt.left_btn, m_left_button);
                check_field("right_button", exp_pkt.right_btn, m_right_button);
                check_field("middle_button", exp_pkt.middle_btn, m_middle_button);
                check_field("x_overflow", exp_pkt.x_ovf, m_x_overflow);
                check_field("y_overflow", exp_pkt.y_ovf, m_y_overflow);
                check_field("delta_x", exp_pkt.dx, m_delta_x);
                check_field("delta_y", exp_pkt.dy, m_delta_y);
                check_field("cursor_x", exp_pkt.cx, m_cursor_x);
                check_field("cursor_y", exp_pkt.cy, m_cursor_y);
                check_field("event_kind", exp_pkt.kind, m_event_kind);
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main_sequence
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_from_aux = 1'b0;
        s_parity_err = 1'b0;
        s_timeout_err = 1'b0;
        send_gap_max = 17;
        stall_max = 17;
        hold_cycles = 0;
        mdl_pos = POS_HEADER;
        mdl_header = 8'h00;
        mdl_xbyte = 8'h00;
        mdl_buttons = 3'b000;
        mdl_col = CURSOR_RESET;
        mdl_row = CURSOR_RESET;
        mdl_width = WIDTH_RESET;
        mdl_height = HEIGHT_RESET;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_directed_packets();
        test_screen_limits();
        test_backpressure();
        test_random_traffic();

        repeat (10) @(negedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
